// ----- rtl/core/i2cbm_pkg.sv -----
package i2cbm_pkg;

	// Command and tick codes of the action field; a command code doubles as the op code
	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_INIT  = 3'd5
	} op_t;

	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_WRITE = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;
	localparam logic [2:0] ACT_INIT  = 3'd5;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd16;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

	// Number of line phases in the current bit slot
	function automatic logic [1:0] phase_count(input op_t op, input logic [3:0] bit_idx);
		logic [1:0] n;
		n = 2'd1;
		unique case (op)
			OP_START: n = 2'd3;
			OP_STOP:  n = 2'd2;
			OP_INIT:  n = 2'd1;
			OP_WRITE: n = (bit_idx < BITS_PER_BYTE) ? 2'd3 : 2'd2;
			OP_READ: begin
				if (bit_idx < BITS_PER_BYTE)
					n = 2'd2;
				else if (bit_idx == BITS_PER_BYTE)
					n = 2'd3;
				else
					n = 2'd1;
			end
			default: n = 2'd1;
		endcase
		return n;
	endfunction

	// Index of the last bit slot of a command
	function automatic logic [3:0] last_bit(input op_t op);
		logic [3:0] n;
		n = 4'd0;
		if (op == OP_WRITE)
			n = BITS_PER_BYTE;
		else if (op == OP_READ)
			n = BITS_PER_BYTE + 4'd1;
		return n;
	endfunction

endpackage

// ----- rtl/core/i2cbm_in_if.sv -----
interface i2cbm_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data_byte;
	logic       send_ack;
	logic       sda_in;

	modport source (output valid, action, data_byte, send_ack, sda_in, input ready);
	modport sink (input valid, action, data_byte, send_ack, sda_in, output ready);
endinterface

// ----- rtl/core/i2cbm_out_if.sv -----
interface i2cbm_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
		input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
		output ready);
endinterface

// ----- rtl/core/i2cbm_cfg_if.sv -----
interface i2cbm_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] phase_ticks;

	modport source (output valid, phase_ticks, input ready);
	modport sink (input valid, phase_ticks, output ready);
endinterface

// ----- rtl/core/i2c_bit_level_master.sv -----
// Channel   | Dir | Payload
// ----------+-----+--------------------------------------------------------
// in_item   | in  | action, data_byte, send_ack, sda_in
// out_item  | out | scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen
// cfg       | in  | phase_ticks
//
// One item per cycle while in_item.ready is high: each transfer updates the
// sequencer state in the same cycle and its result lands in a single output register.
// in_item.ready is high whenever the output register is empty or being taken.
// arst_n clears the sequencer to idle with SCL and SDA released, phase_ticks to 16.
// cfg is always ready; a write takes effect on the next item.
module i2c_bit_level_master
	import i2cbm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	i2cbm_in_if.sink     in_item,
	i2cbm_out_if.source  out_item,
	i2cbm_cfg_if.sink    cfg
);

	// Sequencer state
	op_t        op_q, op_n;
	logic [1:0] ph_q, ph_n;
	logic [3:0] bit_q, bit_n;
	logic [7:0] shift_q, shift_n;
	logic [7:0] delay_q, delay_n;
	logic       scl_q, scl_n;
	logic       sda_q, sda_n;
	logic       ack_q, ack_n;
	logic [7:0] rx_q, rx_n;
	logic       nack_q, nack_n;
	logic       done_n;
	logic [7:0] ticks_q;

	// Output register
	logic       out_valid_q;
	logic       out_scl_q, out_sda_q, out_busy_q, out_done_q, out_ack_q;
	logic [7:0] out_rx_q;

	logic       take;
	logic       enter;
	logic [2:0] ph_inc;
	logic [3:0] bit_inc;
	logic       wbit;

	assign in_item.ready = !out_valid_q || out_item.ready;
	assign take          = in_item.valid && in_item.ready;
	assign cfg.ready     = 1'b1;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ticks_q <= PHASE_TICKS_RST;
		else if (cfg.valid)
			ticks_q <= cfg.phase_ticks;
	end

	// Next state: command start, tick advance, then the levels of the phase entered
	always_comb begin
		op_n    = op_q;
		ph_n    = ph_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		delay_n = delay_q;
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		rx_n    = rx_q;
		nack_n  = nack_q;
		done_n  = 1'b0;
		enter   = 1'b0;
		ph_inc  = 3'd0;
		bit_inc = 4'd0;
		wbit    = 1'b0;

		if (op_q == OP_IDLE) begin
			if (in_item.action >= ACT_START && in_item.action <= ACT_INIT) begin
				op_n  = op_t'(in_item.action);
				ph_n  = 2'd0;
				bit_n = 4'd0;
				if (in_item.action == ACT_WRITE)
					shift_n = in_item.data_byte;
				if (in_item.action == ACT_READ) begin
					shift_n = 8'd0;
					nack_n  = !in_item.send_ack;
				end
				enter = 1'b1;
			end
		end else if (in_item.action == ACT_TICK) begin
			if (delay_q > 8'd1) begin
				delay_n = delay_q - 8'd1;
			end else begin
				delay_n = 8'd0;
				ph_inc  = {1'b0, ph_q} + 3'd1;
				bit_inc = bit_q;
				if (ph_inc >= {1'b0, phase_count(op_q, bit_q)}) begin
					ph_inc  = 3'd0;
					bit_inc = bit_q + 4'd1;
				end
				if (bit_inc > last_bit(op_q)) begin
					op_n   = OP_IDLE;
					ph_n   = 2'd0;
					bit_n  = 4'd0;
					done_n = 1'b1;
				end else begin
					ph_n  = ph_inc[1:0];
					bit_n = bit_inc;
					enter = 1'b1;
				end
			end
		end

		if (enter) begin
			unique case (op_n)
				OP_INIT: begin
					scl_n = 1'b1;
					sda_n = 1'b1;
				end
				OP_START: begin
					if (ph_n == 2'd0) begin
						scl_n = 1'b1;
						sda_n = 1'b1;
					end else if (ph_n == 2'd1) begin
						sda_n = 1'b0;
					end else begin
						scl_n = 1'b0;
					end
				end
				OP_STOP: begin
					if (ph_n == 2'd0)
						scl_n = 1'b1;
					else
						sda_n = 1'b1;
				end
				OP_WRITE: begin
					if (bit_n < BITS_PER_BYTE) begin
						// Data bit, most significant first; SDA falls again after a one
						wbit = shift_n[3'd7 - bit_n[2:0]];
						if (ph_n == 2'd0) begin
							sda_n = wbit;
							scl_n = 1'b1;
						end else if (ph_n == 2'd1) begin
							scl_n = 1'b0;
						end else if (wbit) begin
							sda_n = 1'b0;
						end
					end else begin
						// Slave ack slot
						if (ph_n == 2'd0) begin
							sda_n = 1'b1;
							scl_n = 1'b1;
						end else begin
							scl_n = 1'b0;
							ack_n = in_item.sda_in;
						end
					end
				end
				OP_READ: begin
					if (bit_n < BITS_PER_BYTE) begin
						if (ph_n == 2'd0) begin
							sda_n = 1'b1;
							scl_n = 1'b1;
						end else begin
							scl_n   = 1'b0;
							shift_n = {shift_n[6:0], in_item.sda_in};
						end
					end else if (bit_n == BITS_PER_BYTE) begin
						// Master ack or nack slot
						if (ph_n == 2'd0) begin
							rx_n  = shift_n;
							sda_n = nack_n;
							scl_n = 1'b1;
						end else if (ph_n == 2'd1) begin
							scl_n = 1'b0;
						end else if (nack_n) begin
							sda_n = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
			delay_n = (ticks_q != 8'd0) ? ticks_q : 8'd1;
		end
	end

	// State registers, advanced on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_IDLE;
			ph_q    <= 2'd0;
			bit_q   <= 4'd0;
			shift_q <= 8'd0;
			delay_q <= 8'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			rx_q    <= 8'd0;
			nack_q  <= 1'b0;
		end else if (take) begin
			op_q    <= op_n;
			ph_q    <= ph_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			delay_q <= delay_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			ack_q   <= ack_n;
			rx_q    <= rx_n;
			nack_q  <= nack_n;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (out_item.ready)
			out_valid_q <= 1'b0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_scl_q  <= scl_n;
			out_sda_q  <= sda_n;
			out_busy_q <= (op_n != OP_IDLE);
			out_done_q <= done_n;
			out_rx_q   <= rx_n;
			out_ack_q  <= ack_n;
		end
	end

	// Result channel drive
	always_comb begin
		out_item.valid    = out_valid_q;
		out_item.scl_out  = out_scl_q;
		out_item.sda_out  = out_sda_q;
		out_item.busy_res = out_busy_q;
		out_item.done_res = out_done_q;
		out_item.rx_byte  = out_rx_q;
		out_item.ack_seen = out_ack_q;
	end

endmodule

// ----- tb/i2cbm_checker.sv -----
`timescale 1ns / 1ps

// Watches the three channels, keeps its own model of the line sequencer and
// compares every output transfer against the oldest predicted line state.
module i2cbm_checker
	import i2cbm_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	i2cbm_in_if   in_mon,
	i2cbm_out_if  out_mon,
	i2cbm_cfg_if  cfg_mon,
	output int    pending,
	output int    fail_count
);

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       ack;
	} line_res_t;

	line_res_t line_q[$];
	int        mismatch_cnt;

	// Sequencer model state
	op_t        cur_op;
	logic [4:0] ph_idx;
	logic [3:0] slot;
	logic [7:0] shreg;
	logic [7:0] dly;
	logic [7:0] ptk;
	logic [7:0] rx_hold;
	logic       scl_lvl;
	logic       sda_lvl;
	logic       ack_lvl;
	logic       nack_lvl;

	// One data bit on the wire: set SDA with SCL high, drop SCL, then pull SDA low after a one
	function automatic void drive_data_bit(input logic b, input logic [4:0] ph);
		if (ph == 5'd0) begin
			sda_lvl = b;
			scl_lvl = 1'b1;
		end else if (ph == 5'd1) begin
			scl_lvl = 1'b0;
		end else if (b) begin
			sda_lvl = 1'b0;
		end
	endfunction

	// Line levels set on entry to the current phase, and the reload of the phase delay
	function automatic void enter_line_phase(input logic pin);
		case (cur_op)
			OP_INIT: begin
				scl_lvl = 1'b1;
				sda_lvl = 1'b1;
			end
			OP_START: begin
				if (ph_idx == 5'd0) begin
					scl_lvl = 1'b1;
					sda_lvl = 1'b1;
				end else if (ph_idx == 5'd1) begin
					sda_lvl = 1'b0;
				end else begin
					scl_lvl = 1'b0;
				end
			end
			OP_STOP: begin
				if (ph_idx == 5'd0)
					scl_lvl = 1'b1;
				else
					sda_lvl = 1'b1;
			end
			OP_WRITE: begin
				if (slot < 4'd8) begin
					drive_data_bit(shreg[3'd7 - slot[2:0]], ph_idx);
				end else if (ph_idx == 5'd0) begin
					sda_lvl = 1'b1;
					scl_lvl = 1'b1;
				end else begin
					// slave ack sampled as SCL drops
					scl_lvl = 1'b0;
					ack_lvl = pin;
				end
			end
			OP_READ: begin
				if (slot < 4'd8) begin
					if (ph_idx == 5'd0) begin
						sda_lvl = 1'b1;
						scl_lvl = 1'b1;
					end else begin
						scl_lvl = 1'b0;
						shreg = {shreg[6:0], pin};
					end
				end else if (slot == 4'd8) begin
					if (ph_idx == 5'd0)
						rx_hold = shreg;
					drive_data_bit(nack_lvl, ph_idx);
				end
			end
			default: ;
		endcase
		dly = (ptk == 8'd0) ? 8'd1 : ptk;
	endfunction

	// Advance the model by one accepted item and queue the line state it leaves behind
	function automatic void line_step(input logic [2:0] act, input logic [7:0] dat,
		input logic ack, input logic pin);
		logic [1:0] n_ph;
		logic [3:0] top_slot;
		logic       fin;
		fin = 1'b0;
		if (cur_op == OP_IDLE) begin
			if (act >= ACT_START && act <= ACT_INIT) begin
				cur_op = op_t'(act);
				ph_idx = 5'd0;
				slot = 4'd0;
				if (act == ACT_WRITE)
					shreg = dat;
				if (act == ACT_READ) begin
					shreg = 8'd0;
					nack_lvl = !ack;
				end
				enter_line_phase(pin);
			end
		end else if (act == ACT_TICK) begin
			if (dly > 8'd1) begin
				dly = dly - 8'd1;
			end else begin
				dly = 8'd0;
				case (cur_op)
					OP_START: n_ph = 2'd3;
					OP_STOP:  n_ph = 2'd2;
					OP_WRITE: n_ph = (slot < 4'd8) ? 2'd3 : 2'd2;
					OP_READ:  n_ph = (slot < 4'd8) ? 2'd2 : ((slot == 4'd8) ? 2'd3 : 2'd1);
					default:  n_ph = 2'd1;
				endcase
				top_slot = (cur_op == OP_WRITE) ? 4'd8 : ((cur_op == OP_READ) ? 4'd9 : 4'd0);
				ph_idx = ph_idx + 5'd1;
				if (ph_idx >= n_ph) begin
					ph_idx = 5'd0;
					slot = slot + 4'd1;
				end
				if (slot > top_slot) begin
					cur_op = OP_IDLE;
					ph_idx = 5'd0;
					slot = 4'd0;
					fin = 1'b1;
				end else begin
					enter_line_phase(pin);
				end
			end
		end
		line_q.push_back('{scl: scl_lvl, sda: sda_lvl, busy: (cur_op != OP_IDLE),
			done: fin, rx: rx_hold, ack: ack_lvl});
	endfunction

	// Compare output transfers first, then input transfers, then config writes of this edge
	always @(posedge clk or negedge arst_n) begin : watch
		line_res_t exp_r;
		line_res_t got_r;
		if (!arst_n) begin
			line_q.delete();
			mismatch_cnt = 0;
			cur_op = OP_IDLE;
			ph_idx = 5'd0;
			slot = 4'd0;
			shreg = 8'd0;
			dly = 8'd0;
			ptk = PHASE_TICKS_RST;
			rx_hold = 8'd0;
			scl_lvl = 1'b1;
			sda_lvl = 1'b1;
			ack_lvl = 1'b0;
			nack_lvl = 1'b0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got_r = '{scl: out_mon.scl_out, sda: out_mon.sda_out, busy: out_mon.busy_res,
					done: out_mon.done_res, rx: out_mon.rx_byte, ack: out_mon.ack_seen};
				if (line_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: result transfer with nothing expected", $time);
					mismatch_cnt++;
				end else begin
					exp_r = line_q.pop_front();
					if (got_r.scl !== exp_r.scl || got_r.sda !== exp_r.sda ||
						got_r.busy !== exp_r.busy || got_r.done !== exp_r.done ||
						got_r.rx !== exp_r.rx || got_r.ack !== exp_r.ack) begin
						if (mismatch_cnt < 10) begin
							$write("%0t: mismatch exp/got scl %b/%b sda %b/%b busy %b/%b",
								$time, exp_r.scl, got_r.scl, exp_r.sda, got_r.sda,
								exp_r.busy, got_r.busy);
							$display(" done %b/%b rx %h/%h ack %b/%b",
								exp_r.done, got_r.done, exp_r.rx, got_r.rx,
								exp_r.ack, got_r.ack);
						end
						mismatch_cnt++;
					end
				end
			end
			// an item at the same edge as a config write still sees the old setting
			if (in_mon.valid && in_mon.ready)
				line_step(in_mon.action, in_mon.data_byte, in_mon.send_ack, in_mon.sda_in);
			if (cfg_mon.valid && cfg_mon.ready)
				ptk = cfg_mon.phase_ticks;
			fail_count <= mismatch_cnt;
			pending <= line_q.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import i2cbm_pkg::*;

	// action codes the block does not decode
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;

	// SDA pin pattern during the ticks of one command
	localparam int SDA_RAND  = 0;
	localparam int SDA_ONES  = 1;
	localparam int SDA_ZEROS = 2;

	logic       clk;
	logic       arst_n;
	int         pending;
	int         fail_count;
	int         taken;
	int         items_sent;
	int         tx_burst;
	logic [7:0] cur_ptk;

	i2cbm_in_if  in_if ();
	i2cbm_out_if out_if ();
	i2cbm_cfg_if cfg_if ();

	i2c_bit_level_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_if),
		.out_item (out_if),
		.cfg      (cfg_if)
	);

	i2cbm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_if),
		.out_mon    (out_if),
		.cfg_mon    (cfg_if),
		.pending    (pending),
		.fail_count (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("** i2c_bit_level_master: FAILED **");
		$finish;
	end

	// Mostly no gap, some short ones, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// One input transfer; called and returning at a falling edge
	task automatic send_item(input logic [2:0] act, input logic [7:0] dat, input logic ack,
		input logic pin);
		int n;
		if (tx_burst > 0) begin
			tx_burst--;
			n = 0;
		end else begin
			n = gap_len();
			if ($urandom_range(0, 24) == 0)
				tx_burst = $urandom_range(20, 150);
		end
		if (n > 0) begin
			in_if.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.action <= act;
		in_if.data_byte <= dat;
		in_if.send_ack <= ack;
		in_if.sda_in <= pin;
		do @(posedge clk); while (!in_if.ready);
		@(negedge clk);
	endtask

	// Issue a command and feed exactly the ticks it needs, with ignored items mixed in
	task automatic run_cmd(input logic [2:0] act, input logic [7:0] dat, input logic ack,
		input int sda_mode, input int noise_pct);
		int   n_ticks;
		logic pin;
		case (act)
			ACT_START: n_ticks = 3;
			ACT_STOP:  n_ticks = 2;
			ACT_WRITE: n_ticks = 26;
			ACT_READ:  n_ticks = 20;
			default:   n_ticks = 1;
		endcase
		n_ticks = n_ticks * cur_ptk;
		send_item(act, dat, ack, 1'($urandom));
		for (int i = 0; i < n_ticks; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(3'($urandom_range(ACT_START, ACT_RSVD7)), 8'($urandom),
					1'($urandom), 1'($urandom));
			pin = (sda_mode == SDA_ONES) ? 1'b1 :
				((sda_mode == SDA_ZEROS) ? 1'b0 : 1'($urandom));
			send_item(ACT_TICK, 8'($urandom), 1'($urandom), pin);
		end
		items_sent += n_ticks + 1;
	endtask

	// Something the idle block ignores: a tick or an undecoded action
	task automatic idle_noise();
		logic [2:0] act;
		case ($urandom_range(0, 2))
			0:       act = ACT_TICK;
			1:       act = ACT_RSVD6;
			default: act = ACT_RSVD7;
		endcase
		send_item(act, 8'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Stop offering and wait until every predicted result has been taken
	task automatic drain();
		in_if.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_phase_ticks(input logic [7:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.phase_ticks <= v;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		cur_ptk = v;
	endtask

	// Count result transfers so the receiver knows when to hold off
	always @(posedge clk)
		if (!arst_n)
			taken <= 0;
		else if (out_if.valid && out_if.ready)
			taken <= taken + 1;

	// Result side: random stalls, stretches with none, and one long hold-off
	initial begin : receiver
		int  stall_left;
		int  burst_left;
		int  hold_left;
		bit  held;
		stall_left = 0;
		burst_left = 0;
		hold_left = 0;
		held = 1'b0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_if.ready <= 1'b0;
				hold_left--;
			end else if (!held && taken >= 300) begin
				held = 1'b1;
				hold_left = 80;
				out_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				out_if.ready <= 1'b0;
				stall_left--;
			end else if (burst_left > 0) begin
				out_if.ready <= 1'b1;
				burst_left--;
			end else begin
				out_if.ready <= 1'b1;
				stall_left = gap_len();
				if ($urandom_range(0, 19) == 0)
					burst_left = $urandom_range(20, 200);
			end
		end
	end

	// Stimulus: reset, directed commands, then random command streams over several settings
	initial begin : stimulus
		logic [7:0] ptk_plan [6];
		logic [7:0] ptk_v;
		logic [2:0] act;
		int         r;
		int         mode;
		int         phase_end;
		int         base;
		bit         paused;
		ptk_plan = '{8'd1, 8'd2, 8'd1, 8'd3, 8'd6, 8'd1};
		items_sent = 0;
		tx_burst = 0;
		paused = 1'b0;
		cur_ptk = PHASE_TICKS_RST;
		in_if.valid = 1'b0;
		in_if.action = ACT_TICK;
		in_if.data_byte = 8'd0;
		in_if.send_ack = 1'b0;
		in_if.sda_in = 1'b1;
		cfg_if.valid = 1'b0;
		cfg_if.phase_ticks = PHASE_TICKS_RST;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default phase length after reset
		run_cmd(ACT_INIT, 8'h00, 1'b0, SDA_RAND, 0);
		run_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 0);
		run_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 0);
		drain();

		// directed: line corner cases at the shortest phase
		set_phase_ticks(8'd1);
		idle_noise();
		send_item(ACT_RSVD6, 8'hFF, 1'b1, 1'b0);
		send_item(ACT_RSVD7, 8'h00, 1'b0, 1'b1);
		send_item(ACT_TICK, 8'h5A, 1'b1, 1'b0);
		run_cmd(ACT_INIT, 8'h00, 1'b0, SDA_RAND, 0);
		run_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 0);
		// all-ones byte: SDA pulled low after every bit, slave nacks
		run_cmd(ACT_WRITE, 8'hFF, 1'b0, SDA_ONES, 0);
		run_cmd(ACT_WRITE, 8'h00, 1'b1, SDA_ZEROS, 0);
		run_cmd(ACT_READ, 8'h00, 1'b1, SDA_ONES, 0);
		run_cmd(ACT_READ, 8'hFF, 1'b0, SDA_ZEROS, 0);
		// commands and undecoded actions while busy are ignored
		run_cmd(ACT_WRITE, 8'hA5, 1'b1, SDA_RAND, 30);
		run_cmd(ACT_READ, 8'h3C, 1'b1, SDA_RAND, 30);
		// stop right after a start: SDA rises without being lowered first
		run_cmd(ACT_START, 8'h00, 1'b0, SDA_RAND, 0);
		run_cmd(ACT_STOP, 8'h00, 1'b0, SDA_RAND, 0);
		idle_noise();
		drain();

		// longest phase, short commands only
		set_phase_ticks(8'd255);
		run_cmd(ACT_INIT, 8'h00, 1'b0, SDA_RAND, 3);
		drain();

		// random command streams
		base = items_sent;
		for (int p = 0; p < 6; p++) begin
			ptk_v = (p == 4) ? 8'($urandom_range(4, 8)) : ptk_plan[p];
			set_phase_ticks(ptk_v);
			phase_end = items_sent + 60;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				act = (r < 35) ? ACT_WRITE : (r < 70) ? ACT_READ :
					(r < 80) ? ACT_START : (r < 90) ? ACT_STOP : ACT_INIT;
				r = $urandom_range(0, 99);
				mode = (r < 10) ? SDA_ONES : ((r < 20) ? SDA_ZEROS : SDA_RAND);
				run_cmd(act, 8'($urandom), 1'($urandom), mode, 4);
				if ($urandom_range(0, 99) < 15)
					idle_noise();
				// sender waits once for the block to empty out mid-stream
				if (!paused && items_sent - base > 200) begin
					drain();
					paused = 1'b1;
				end
			end
			drain();
		end

		repeat (5) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** i2c_bit_level_master: PASSED **");
		else
			$display("** i2c_bit_level_master: FAILED **");
		$finish;
	end

endmodule

// ----- i2c_bit_level_master.f -----
rtl/core/i2cbm_pkg.sv
rtl/core/i2cbm_in_if.sv
rtl/core/i2cbm_out_if.sv
rtl/core/i2cbm_cfg_if.sv
rtl/core/i2c_bit_level_master.sv
tb/i2cbm_checker.sv
tb/testbench.sv
